FILE: rtl/core/nrlc_pkg.sv
// ----------------------------------------------------------------------------
// nrlc_pkg
// Shared types and constants for the NAK range list checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nrlc_pkg;

    localparam int DATA_W  = 8;
    localparam int VALUE_W = 24;
    localparam int COUNT_W = 16;
    localparam int TOTAL_W = 40;
    localparam int VERD_W  = 3;
    localparam int OUT_W   = 48;

    localparam logic [VALUE_W-1:0] FULL_VALUE = 24'hFFFFFF;

    localparam logic [VERD_W-1:0] VERDICT_FORWARD     = 3'd0;
    localparam logic [VERD_W-1:0] VERDICT_FLOOD_CHECK = 3'd1;
    localparam logic [VERD_W-1:0] VERDICT_DROP_BANNED = 3'd2;
    localparam logic [VERD_W-1:0] VERDICT_DROP_REV    = 3'd3;
    localparam logic [VERD_W-1:0] VERDICT_BAN_SOURCE  = 3'd4;
    localparam logic [VERD_W-1:0] VERDICT_DROP_FULL   = 3'd5;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_COUNT  = 6'b000010,
        PH_FLAG   = 6'b000100,
        PH_LOW    = 6'b001000,
        PH_HIGH   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              first;
        logic              last;
        logic              known;
        logic              banned;
    } in_word_t;

    typedef struct packed {
        logic               valid;
        logic [VERD_W-1:0]  verdict;
        logic [TOTAL_W-1:0] total;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/nrlc_parser.sv
// ----------------------------------------------------------------------------
// nrlc_parser
// Datagram parse state; one byte per step, verdict on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nrlc_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire nrlc_pkg::in_word_t word,
    output nrlc_pkg::result_t       result
);

    nrlc_pkg::phase_t                    phase_reg, phase_next, phase_parsed;
    logic [1:0]                          idx_reg, idx_next;
    logic [1:0]                          bc_reg, bc_next;
    logic [nrlc_pkg::COUNT_W-1:0]        expected_reg, expected_next;
    logic [nrlc_pkg::COUNT_W-1:0]        done_reg, done_next;
    logic                                entry_reg, entry_next;
    logic [nrlc_pkg::VALUE_W-1:0]        low_reg, low_next;
    logic [nrlc_pkg::VALUE_W-1:0]        high_reg, high_next;
    logic [nrlc_pkg::TOTAL_W-1:0]        total_reg, total_next;
    logic [nrlc_pkg::VERD_W-1:0]         decided_reg, decided_next;
    logic                                fixed_reg, fixed_next;
    logic                                known_reg, known_next;
    logic                                banned_reg, banned_next;

    logic [nrlc_pkg::DATA_W-1:0]         d;
    logic [nrlc_pkg::VALUE_W-1:0]        field_shift;
    logic [nrlc_pkg::VALUE_W-1:0]        span;
    logic                                finish;
    logic [nrlc_pkg::VERD_W-1:0]         verdict;

    assign d = word.data;

    always_comb
    begin
        case (idx_reg)
            2'd0:    field_shift = {16'h0000, d};
            2'd1:    field_shift = {8'h00, d, 8'h00};
            2'd2:    field_shift = {d, 16'h0000};
            default: field_shift = '0;
        endcase
    end

    always_comb
    begin
        phase_parsed  = phase_reg;
        idx_next      = idx_reg;
        bc_next       = bc_reg;
        expected_next = expected_reg;
        done_next     = done_reg;
        entry_next    = entry_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        total_next    = total_reg;
        decided_next  = decided_reg;
        fixed_next    = fixed_reg;
        known_next    = known_reg;
        banned_next   = banned_reg;
        finish        = 1'b0;
        span          = high_next - low_next;

        if (step)
        begin
            if (word.first || phase_reg == nrlc_pkg::PH_HEADER)
            begin
                idx_next      = '0;
                expected_next = '0;
                done_next     = '0;
                entry_next    = 1'b0;
                low_next      = '0;
                high_next     = '0;
                total_next    = '0;
                decided_next  = nrlc_pkg::VERDICT_FORWARD;
                fixed_next    = 1'b0;
                known_next    = word.known;
                banned_next   = word.banned;
                bc_next       = 2'd1;
                // valid NAK: bit 7 set, bit 6 clear, bit 5 set
                if (!d[7] || d[6] || !d[5])
                begin
                    decided_next = nrlc_pkg::VERDICT_FORWARD;
                    fixed_next   = 1'b1;
                    phase_parsed = nrlc_pkg::PH_DONE;
                end
                else
                begin
                    phase_parsed = nrlc_pkg::PH_COUNT;
                end
            end
            else
            begin
                if (bc_reg != 2'd3)
                begin
                    bc_next = bc_reg + 2'd1;
                end
                case (phase_reg)
                    nrlc_pkg::PH_COUNT:
                    begin
                        expected_next = {expected_reg[7:0], d};
                        if (bc_next == 2'd3)
                        begin
                            if (known_reg && banned_reg)
                            begin
                                decided_next = nrlc_pkg::VERDICT_DROP_BANNED;
                                fixed_next   = 1'b1;
                                phase_parsed = nrlc_pkg::PH_DONE;
                            end
                            else if (expected_next == '0)
                            begin
                                phase_parsed = nrlc_pkg::PH_DONE;
                            end
                            else
                            begin
                                phase_parsed = nrlc_pkg::PH_FLAG;
                            end
                        end
                    end
                    nrlc_pkg::PH_FLAG:
                    begin
                        entry_next   = (d == '0);
                        idx_next     = '0;
                        low_next     = '0;
                        high_next    = '0;
                        phase_parsed = nrlc_pkg::PH_LOW;
                    end
                    nrlc_pkg::PH_LOW:
                    begin
                        low_next = low_reg | field_shift;
                        if (idx_reg == 2'd2)
                        begin
                            idx_next = '0;
                            if (entry_reg)
                            begin
                                phase_parsed = nrlc_pkg::PH_HIGH;
                            end
                            else
                            begin
                                high_next = low_next;
                                finish    = 1'b1;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    nrlc_pkg::PH_HIGH:
                    begin
                        high_next = high_reg | field_shift;
                        if (idx_reg == 2'd2)
                        begin
                            idx_next = '0;
                            finish   = 1'b1;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                span = high_next - low_next;
                if (finish)
                begin
                    if (high_next < low_next)
                    begin
                        decided_next = nrlc_pkg::VERDICT_DROP_REV;
                        fixed_next   = 1'b1;
                        phase_parsed = nrlc_pkg::PH_DONE;
                    end
                    else if (low_next == '0 && high_next == nrlc_pkg::FULL_VALUE)
                    begin
                        decided_next = known_reg ? nrlc_pkg::VERDICT_BAN_SOURCE
                                                 : nrlc_pkg::VERDICT_DROP_FULL;
                        fixed_next   = 1'b1;
                        phase_parsed = nrlc_pkg::PH_DONE;
                    end
                    else
                    begin
                        total_next   = total_reg + {16'h0000, span} + 40'd1;
                        done_next    = done_reg + 16'd1;
                        phase_parsed = (done_next == expected_reg) ? nrlc_pkg::PH_DONE
                                                                   : nrlc_pkg::PH_FLAG;
                    end
                end
            end
        end

        if (fixed_next)
        begin
            verdict = decided_next;
        end
        else if (phase_parsed == nrlc_pkg::PH_DONE && known_next)
        begin
            verdict = nrlc_pkg::VERDICT_FLOOD_CHECK;
        end
        else
        begin
            verdict = nrlc_pkg::VERDICT_FORWARD;
        end

        result.valid   = step && word.last;
        result.verdict = verdict;
        result.total   = (verdict == nrlc_pkg::VERDICT_FLOOD_CHECK) ? total_next : '0;

        phase_next = (step && word.last) ? nrlc_pkg::PH_HEADER : phase_parsed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= nrlc_pkg::PH_HEADER;
            idx_reg      <= '0;
            bc_reg       <= '0;
            expected_reg <= '0;
            done_reg     <= '0;
            entry_reg    <= 1'b0;
            low_reg      <= '0;
            high_reg     <= '0;
            total_reg    <= '0;
            decided_reg  <= '0;
            fixed_reg    <= 1'b0;
            known_reg    <= 1'b0;
            banned_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            bc_reg       <= bc_next;
            expected_reg <= expected_next;
            done_reg     <= done_next;
            entry_reg    <= entry_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            total_reg    <= total_next;
            decided_reg  <= decided_next;
            fixed_reg    <= fixed_next;
            known_reg    <= known_next;
            banned_reg   <= banned_next;
        end
    end

    a_last_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        step && word.last |=> phase_reg == nrlc_pkg::PH_HEADER)
        else $error("phase not back to header after last word");

    a_fixed_done: assert property (@(posedge clk) disable iff (!rst_n)
        fixed_reg |-> (phase_reg == nrlc_pkg::PH_DONE || phase_reg == nrlc_pkg::PH_HEADER))
        else $error("fixed verdict outside done phase");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd3)
        else $error("field byte index out of range");

endmodule

`default_nettype wire

FILE: rtl/core/nrlc_out_stage.sv
// ----------------------------------------------------------------------------
// nrlc_out_stage
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module nrlc_out_stage (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire nrlc_pkg::result_t            result,
    output logic                              slot_free,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [nrlc_pkg::OUT_W-1:0]        m_tdata   // verdict[2:0], total_intervals[42:3]
);

    logic                              valid_reg;
    logic [nrlc_pkg::OUT_W-1:0]        data_reg;

    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            data_reg <= {5'b00000, result.total, result.verdict};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nak_range_list_checker_top.sv
// ----------------------------------------------------------------------------
// nak_range_list_checker_top
// NAK range list checker: one datagram byte per word, one verdict per datagram.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle unless a last byte is stalled; the parse step is combinational.
// Path: after the last byte is accepted it goes through the input register, then parse logic,
//   into the result register, from which m_tvalid rises.
// Stall: a last byte waits in the input register while the result word is held.
// Reset: rst_n async active low; parser returns to header phase, no word held.
// ----------------------------------------------------------------------------
`default_nettype none

module nak_range_list_checker_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [nrlc_pkg::DATA_W-1:0]   s_tdata,   // data_byte[7:0]
    input  wire logic                          s_tlast,   // last_byte
    input  wire logic [2:0]                    s_tuser,   // first_byte[0], source_known[1],
                                                          // source_banned[2]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [nrlc_pkg::OUT_W-1:0]         m_tdata    // verdict[2:0], total_intervals[42:3]
);

    logic               in_valid_reg;
    nrlc_pkg::in_word_t in_word_reg;
    logic               slot_free;
    logic               advance;
    nrlc_pkg::result_t  result;

    assign advance  = in_valid_reg && (!in_word_reg.last || slot_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg.data   <= s_tdata;
            in_word_reg.first  <= s_tuser[0];
            in_word_reg.last   <= s_tlast;
            in_word_reg.known  <= s_tuser[1];
            in_word_reg.banned <= s_tuser[2];
        end
    end

    nrlc_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (in_word_reg),
        .result (result)
    );

    nrlc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> slot_free)
        else $error("result produced while output register is full");

endmodule

`default_nettype wire
